// File: hdl/rgbhsl_pkg.sv
// Shared widths and constants for the RGB to HSL converter.
// No dependencies; every other file in this folder imports it.
package rgbhsl_pkg;

  // Pixel channels and result fields
  localparam int ChanW = 8;
  localparam int HueW  = 9;
  localparam int PctW  = 7;

  // Channel sum (max + min) and the divider operands
  localparam int SumW = ChanW + 1;
  localparam int NumW = 17;
  localparam int DenW = 9;
  localparam int QuoW = 9;

  // Divider pipeline: quotient bits resolved per stage, and stage count
  localparam int DivBitsPerStage = 3;
  localparam int DivStages       = QuoW / DivBitsPerStage;

  // Total latency from accepted transaction to result strobe
  localparam int Latency = DivStages + 1;

  // Hue index width (hue numerator before scaling by 60)
  localparam int HueIdxW = 11;

  // Color constants
  localparam logic [SumW-1:0] HalfSum   = 9'd255;
  localparam logic [SumW-1:0] FullSum   = 9'd510;
  localparam logic [6:0]      HueScale  = 7'd60;
  localparam logic [6:0]      PctScale  = 7'd100;

  // Lightness: floor(10*s/51) by reciprocal multiply, then one correction
  localparam int              LightYW     = 13;
  localparam int              LightProdW  = 24;
  localparam int              LightShift  = 16;
  localparam logic [10:0]     LightRecip  = 11'd1285;
  localparam logic [5:0]      LightDiv    = 6'd51;

endpackage

// File: hdl/rgbhsl_front.sv
// Front stage of the RGB to HSL converter: channel max/min, lightness sum,
// and the hue and saturation divider operands, all registered once.
// Depends on rgbhsl_pkg.
module rgbhsl_front (
  input  logic                         clk,
  input  logic [rgbhsl_pkg::ChanW-1:0] red,
  input  logic [rgbhsl_pkg::ChanW-1:0] green,
  input  logic [rgbhsl_pkg::ChanW-1:0] blue,
  output logic [rgbhsl_pkg::NumW-1:0]  hue_num,
  output logic [rgbhsl_pkg::DenW-1:0]  hue_den,
  output logic [rgbhsl_pkg::NumW-1:0]  sat_num,
  output logic [rgbhsl_pkg::DenW-1:0]  sat_den,
  output logic [rgbhsl_pkg::SumW-1:0]  chan_sum
);
  import rgbhsl_pkg::*;

  logic [ChanW-1:0]   mx;
  logic [ChanW-1:0]   mn;
  logic [ChanW-1:0]   diff;
  logic [SumW-1:0]    sum;
  logic               grey;
  logic signed [11:0] idx_raw;
  logic [11:0]        idx_wrap;
  logic [HueIdxW-1:0] idx;
  logic [NumW-1:0]    hue_num_next;
  logic [NumW-1:0]    sat_num_next;
  logic [DenW-1:0]    hue_den_next;
  logic [DenW-1:0]    sat_den_next;

  // Find the largest and smallest channel
  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx)  mx = blue;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;
    diff = mx - mn;
    sum  = SumW'(mx) + SumW'(mn);
    grey = (diff == '0);
  end

  // Hue index in sixths of diff; ties rank blue over green over red
  always_comb begin
    if (blue == mx) begin
      idx_raw = $signed({2'b00, diff, 2'b00}) + $signed({4'b0000, red})
              - $signed({4'b0000, green});
    end else if (green == mx) begin
      idx_raw = $signed({3'b000, diff, 1'b0}) + $signed({4'b0000, blue})
              - $signed({4'b0000, red});
    end else begin
      idx_raw = $signed({4'b0000, green}) - $signed({4'b0000, blue});
    end
    // Wrap a negative index by a full turn (six sixths)
    if (idx_raw < 0) begin
      idx_wrap = 12'(idx_raw) + {2'b00, diff, 2'b00} + {3'b000, diff, 1'b0};
    end else begin
      idx_wrap = 12'(idx_raw);
    end
    idx = idx_wrap[HueIdxW-1:0];
  end

  // Divider operands; grey forces a unit divisor so the quotient is zero
  always_comb begin
    hue_num_next = NumW'(idx) * NumW'(HueScale);
    sat_num_next = NumW'(diff) * NumW'(PctScale);
    if (grey) begin
      hue_den_next = DenW'(1);
      sat_den_next = DenW'(1);
    end else begin
      hue_den_next = DenW'(diff);
      sat_den_next = (sum < HalfSum) ? DenW'(sum) : DenW'(FullSum - sum);
    end
  end

  // Register the operands
  always_ff @(posedge clk) begin
    hue_num  <= hue_num_next;
    hue_den  <= hue_den_next;
    sat_num  <= sat_num_next;
    sat_den  <= sat_den_next;
    chan_sum <= sum;
  end

endmodule

// File: hdl/rgbhsl_div.sv
// Pipelined restoring divider of the RGB to HSL converter, a few quotient
// bits per register stage. Depends on rgbhsl_pkg.
module rgbhsl_div (
  input  logic                        clk,
  input  logic [rgbhsl_pkg::NumW-1:0] num,
  input  logic [rgbhsl_pkg::DenW-1:0] den,
  output logic [rgbhsl_pkg::QuoW-1:0] quo
);
  import rgbhsl_pkg::*;

  logic [NumW-1:0] rem_q [DivStages];
  logic [DenW-1:0] den_q [DivStages];
  logic [QuoW-1:0] quo_q [DivStages];

  for (genvar j = 0; j < DivStages; j++) begin : g_stage
    logic [NumW-1:0] rem_in;
    logic [DenW-1:0] den_in;
    logic [QuoW-1:0] quo_in;
    logic [NumW-1:0] rem_out;
    logic [QuoW-1:0] quo_out;
    logic [NumW-1:0] trial;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    // Resolve this stage's quotient bits, most significant first
    always_comb begin
      rem_out = rem_in;
      quo_out = quo_in;
      trial   = '0;
      for (int i = 0; i < DivBitsPerStage; i++) begin
        trial = NumW'(den_in) << (QuoW - 1 - j * DivBitsPerStage - i);
        if (rem_out >= trial) begin
          rem_out = rem_out - trial;
          quo_out[QuoW-1-j*DivBitsPerStage-i] = 1'b1;
        end
      end
    end

    // Advance the partial remainder and quotient
    always_ff @(posedge clk) begin
      rem_q[j] <= rem_out;
      den_q[j] <= den_in;
      quo_q[j] <= quo_out;
    end
  end

  assign quo = quo_q[DivStages-1];

endmodule

// File: hdl/rgbhsl_light.sv
// Lightness path of the RGB to HSL converter: floor(100*sum/510) by a
// reciprocal multiply and one correction, timed to match the divider.
// Depends on rgbhsl_pkg.
module rgbhsl_light (
  input  logic                        clk,
  input  logic [rgbhsl_pkg::SumW-1:0] chan_sum,
  output logic [rgbhsl_pkg::PctW-1:0] lightness
);
  import rgbhsl_pkg::*;

  logic [LightYW-1:0]    y;
  logic [LightYW-1:0]    y_q;
  logic [LightProdW-1:0] prod_q;
  logic [PctW-1:0]       est;
  logic [LightYW-1:0]    resid;
  logic [PctW-1:0]       light_next;
  logic [PctW-1:0]       light_q;

  // Scale the sum by ten: 100/510 reduces to 10/51
  assign y = (LightYW'(chan_sum) << 3) + (LightYW'(chan_sum) << 1);

  // Stage one: multiply by the reciprocal (never overestimates)
  always_ff @(posedge clk) begin
    y_q    <= y;
    prod_q <= LightProdW'(y) * LightProdW'(LightRecip);
  end

  // Stage two: fix the estimate up by one where the remainder overflows
  always_comb begin
    est        = prod_q[LightShift +: PctW];
    resid      = y_q - LightYW'(est) * LightYW'(LightDiv);
    light_next = (resid >= LightYW'(LightDiv)) ? est + PctW'(1) : est;
  end

  always_ff @(posedge clk) begin
    light_q <= light_next;
  end

  // Stage three: hold to line up with the divider output
  always_ff @(posedge clk) begin
    lightness <= light_q;
  end

endmodule

// File: hdl/rgb_to_hsl_converter_unit.sv
// RGB to HSL converter: one pixel of 8-bit channels in, whole-degree hue and
// whole-percent saturation and lightness out. Top level.
// Depends on rgbhsl_pkg, rgbhsl_front, rgbhsl_div, rgbhsl_light.
//
// Usage: raise start with a pixel on red/green/blue; a transaction is taken
// at every clock edge where start is high, one per cycle with no gaps.
// busy is held low: the pipeline never stalls. Each result appears on
// hue/saturation/lightness for exactly one cycle, marked by done, after its
// transaction has passed one operand stage and three divider stages, each
// resolving three quotient bits. Results come out in order and the receiver
// must take them as they come. Grey pixels give hue and saturation of zero;
// all quotients are truncated toward zero.
module rgb_to_hsl_converter_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [rgbhsl_pkg::ChanW-1:0] red,
  input  logic [rgbhsl_pkg::ChanW-1:0] green,
  input  logic [rgbhsl_pkg::ChanW-1:0] blue,
  output logic                         done,
  output logic [rgbhsl_pkg::HueW-1:0]  hue,
  output logic [rgbhsl_pkg::PctW-1:0]  saturation,
  output logic [rgbhsl_pkg::PctW-1:0]  lightness
);
  import rgbhsl_pkg::*;

  logic [NumW-1:0]    hue_num;
  logic [DenW-1:0]    hue_den;
  logic [NumW-1:0]    sat_num;
  logic [DenW-1:0]    sat_den;
  logic [SumW-1:0]    chan_sum;
  logic [QuoW-1:0]    hue_quo;
  logic [QuoW-1:0]    sat_quo;
  logic [Latency-1:0] valid;
  logic               accept;

  // The pipeline advances every cycle, so it is never busy
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  rgbhsl_front u_front (
    .clk      (clk),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .hue_num  (hue_num),
    .hue_den  (hue_den),
    .sat_num  (sat_num),
    .sat_den  (sat_den),
    .chan_sum (chan_sum)
  );

  rgbhsl_div u_hue_div (
    .clk (clk),
    .num (hue_num),
    .den (hue_den),
    .quo (hue_quo)
  );

  rgbhsl_div u_sat_div (
    .clk (clk),
    .num (sat_num),
    .den (sat_den),
    .quo (sat_quo)
  );

  rgbhsl_light u_light (
    .clk       (clk),
    .chan_sum  (chan_sum),
    .lightness (lightness)
  );

  // Advance the valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[Latency-2:0], accept};
    end
  end

  assign done       = valid[Latency-1];
  assign hue        = hue_quo[HueW-1:0];
  assign saturation = sat_quo[PctW-1:0];

endmodule
